// File: hw/rtl/bez_pkg.sv
// Shared widths, types and fixed-point helpers for the cubic Bezier block.
package bez_pkg;

    // Coordinate and parameter widths
    localparam int COORD_WIDTH = 32;
    localparam int T_FRAC_BITS = 16;

    localparam int CW = COORD_WIDTH;
    localparam int F  = T_FRAC_BITS;
    localparam int TW = F + 1;                 // t including the 1.0 bit
    localparam int WW = F + 3;                 // Bernstein weight, up to 3.0
    localparam int MW = CW + TW + 2 - F;       // lerp step after the shift
    localparam int EW = CW + WW + 1 - F;       // weighted coordinate after the shift
    localparam int SW = CW + 6;                // sum and saturation width

    localparam logic [TW-1:0] T_ONE = {1'b1, {F{1'b0}}};

    // Configuration port sizes
    localparam int DATA_W = (CW > 32) ? 64 : 32;
    localparam int ADDR_W = $clog2(8 * (DATA_W / 8));
    localparam int NPTS   = 8;

    // Register indexes
    typedef enum logic [2:0] {
        REG_P0_X = 3'd0,
        REG_P0_Y = 3'd1,
        REG_P1_X = 3'd2,
        REG_P1_Y = 3'd3,
        REG_P2_X = 3'd4,
        REG_P2_Y = 3'd5,
        REG_P3_X = 3'd6,
        REG_P3_Y = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } point_t;

    typedef struct packed {
        logic signed [MW-1:0] x;
        logic signed [MW-1:0] y;
    } step_t;

    typedef struct packed {
        logic signed [EW-1:0] x;
        logic signed [EW-1:0] y;
    } wpoint_t;

    // Control points P0..P3
    typedef struct packed {
        point_t [3:0] p;
    } ctl_t;

    // One finished request, in output order
    typedef struct packed {
        logic                split;
        point_t [NPTS-1:0]   pt;
    } res_t;

    // Clamp a wide sum to the coordinate range
    function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
        if (v > hi)
            return hi[CW-1:0];
        else if (v < lo)
            return lo[CW-1:0];
        else
            return v[CW-1:0];
    endfunction

    // floor((q - p) * t / 2^F)
    function automatic logic signed [MW-1:0] lerp_mul(input logic signed [CW-1:0] p,
                                                      input logic signed [CW-1:0] q,
                                                      input logic [TW-1:0] t);
        logic signed [CW:0]        dif;
        logic signed [CW+TW+1:0]   prod;
        dif  = {q[CW-1], q} - {p[CW-1], p};
        prod = dif * $signed({1'b0, t});
        return prod[CW+TW+1:F];
    endfunction

    // p + step, saturated
    function automatic logic signed [CW-1:0] lerp_add(input logic signed [CW-1:0] p,
                                                      input logic signed [MW-1:0] m);
        logic signed [SW-1:0] s;
        s = {{(SW-CW){p[CW-1]}}, p} + {{(SW-MW){m[MW-1]}}, m};
        return sat(s);
    endfunction

    // floor(p * w / 2^F)
    function automatic logic signed [EW-1:0] wmul(input logic signed [CW-1:0] p,
                                                  input logic [WW-1:0] w);
        logic signed [CW+WW:0] prod;
        prod = p * $signed({1'b0, w});
        return prod[CW+WW:F];
    endfunction

    // Sign-extend a weighted coordinate to the sum width
    function automatic logic signed [SW-1:0] ext_w(input logic signed [EW-1:0] v);
        return {{(SW-EW){v[EW-1]}}, v};
    endfunction

endpackage

// File: hw/rtl/bez_cfg.sv
// APB register file holding the four control points.
module bez_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bez_pkg::ADDR_W-1:0]        paddr,
    input  logic [bez_pkg::DATA_W-1:0]        pwdata,
    output logic [bez_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    output bez_pkg::ctl_t                     ctl
);

    bez_pkg::ctl_t              ctl_reg;
    bez_pkg::ctl_t              ctl_next;
    bez_pkg::reg_idx_t          idx;
    logic                       wr_en;
    logic signed [bez_pkg::CW-1:0] wr_val;
    logic signed [bez_pkg::CW-1:0] rd_val;

    assign pready = 1'b1;
    assign idx    = bez_pkg::reg_idx_t'(paddr[bez_pkg::ADDR_W-1:bez_pkg::ADDR_W-3]);
    assign wr_en  = psel && penable && pwrite;
    assign wr_val = pwdata[bez_pkg::CW-1:0];

    // Decode the write
    always_comb
    begin
        ctl_next = ctl_reg;
        if (wr_en)
        begin
            unique case (idx)
                bez_pkg::REG_P0_X: ctl_next.p[0].x = wr_val;
                bez_pkg::REG_P0_Y: ctl_next.p[0].y = wr_val;
                bez_pkg::REG_P1_X: ctl_next.p[1].x = wr_val;
                bez_pkg::REG_P1_Y: ctl_next.p[1].y = wr_val;
                bez_pkg::REG_P2_X: ctl_next.p[2].x = wr_val;
                bez_pkg::REG_P2_Y: ctl_next.p[2].y = wr_val;
                bez_pkg::REG_P3_X: ctl_next.p[3].x = wr_val;
                bez_pkg::REG_P3_Y: ctl_next.p[3].y = wr_val;
                default:           ctl_next = ctl_reg;
            endcase
        end
    end

    // Decode the read
    always_comb
    begin
        unique case (idx)
            bez_pkg::REG_P0_X: rd_val = ctl_reg.p[0].x;
            bez_pkg::REG_P0_Y: rd_val = ctl_reg.p[0].y;
            bez_pkg::REG_P1_X: rd_val = ctl_reg.p[1].x;
            bez_pkg::REG_P1_Y: rd_val = ctl_reg.p[1].y;
            bez_pkg::REG_P2_X: rd_val = ctl_reg.p[2].x;
            bez_pkg::REG_P2_Y: rd_val = ctl_reg.p[2].y;
            bez_pkg::REG_P3_X: rd_val = ctl_reg.p[3].x;
            bez_pkg::REG_P3_Y: rd_val = ctl_reg.p[3].y;
            default:           rd_val = '0;
        endcase
    end

    assign prdata = bez_pkg::DATA_W'(rd_val);
    assign ctl    = ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_next;
    end

endmodule

// File: hw/rtl/bez_datapath.sv
// Seven-stage pipeline computing the Bernstein point and the de Casteljau split.
module bez_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bez_pkg::ctl_t               ctl,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [bez_pkg::TW-1:0]      t_param,
    output logic                        res_valid,
    input  logic                        res_ready,
    output bez_pkg::res_t               res
);

    localparam int TW = bez_pkg::TW;
    localparam int WW = bez_pkg::WW;
    localparam int F  = bez_pkg::F;

    // Stage valid bits and ready chain
    logic [6:0] v_reg;
    logic [6:0] v_next;
    logic [6:0] rdy;

    // Stage 0: clamped t and 1 - t
    logic           split0_reg, split0_next;
    logic [TW-1:0]  t0_reg, t0_next;
    logic [TW-1:0]  d0_reg, d0_next;

    // Stage 1: squares and first-level steps
    logic           split1_reg, split1_next;
    logic [TW-1:0]  t1_reg, t1_next;
    logic [TW-1:0]  d1_reg, d1_next;
    logic [TW-1:0]  dd1_reg, dd1_next;
    logic [TW-1:0]  tt1_reg, tt1_next;
    bez_pkg::step_t m1_reg [3];
    bez_pkg::step_t m1_next [3];

    // Stage 2: weights and a, b, c
    logic           split2_reg, split2_next;
    logic [TW-1:0]  t2_reg, t2_next;
    logic [WW-1:0]  w2_reg [4];
    logic [WW-1:0]  w2_next [4];
    bez_pkg::point_t l2_reg [3];
    bez_pkg::point_t l2_next [3];

    // Stage 3: weighted points and second-level steps
    logic           split3_reg, split3_next;
    logic [TW-1:0]  t3_reg, t3_next;
    bez_pkg::wpoint_t e3_reg [4];
    bez_pkg::wpoint_t e3_next [4];
    bez_pkg::point_t l3_reg [3];
    bez_pkg::point_t l3_next [3];
    bez_pkg::step_t m3_reg [2];
    bez_pkg::step_t m3_next [2];

    // Stage 4: evaluated point, ab and bc
    logic           split4_reg, split4_next;
    logic [TW-1:0]  t4_reg, t4_next;
    bez_pkg::point_t ev4_reg, ev4_next;
    bez_pkg::point_t a4_reg, a4_next;
    bez_pkg::point_t c4_reg, c4_next;
    bez_pkg::point_t ab4_reg, ab4_next;
    bez_pkg::point_t bc4_reg, bc4_next;

    // Stage 5: last step
    logic           split5_reg, split5_next;
    bez_pkg::point_t ev5_reg, ev5_next;
    bez_pkg::point_t a5_reg, a5_next;
    bez_pkg::point_t c5_reg, c5_next;
    bez_pkg::point_t ab5_reg, ab5_next;
    bez_pkg::point_t bc5_reg, bc5_next;
    bez_pkg::step_t  m5_reg, m5_next;

    // Stage 6: abc
    logic           split6_reg, split6_next;
    bez_pkg::point_t ev6_reg, ev6_next;
    bez_pkg::point_t a6_reg, a6_next;
    bez_pkg::point_t c6_reg, c6_next;
    bez_pkg::point_t ab6_reg, ab6_next;
    bez_pkg::point_t bc6_reg, bc6_next;
    bez_pkg::point_t abc6_reg, abc6_next;

    // Scratch products
    logic [2*TW-1:0]    pdd, ptt, pw0, pw3, pw1, pw2;
    logic [2*TW+1:0]    pw1x3, pw2x3;
    logic [TW-1:0]      tc;

    // Advance a stage when it is empty or its successor advances
    always_comb
    begin
        rdy[6] = !v_reg[6] || res_ready;
        for (int k = 5; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
        v_next[0] = rdy[0] ? in_valid : v_reg[0];
        for (int k = 1; k < 7; k++)
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
    end

    assign in_stall = !rdy[0];

    // Stage 0: clamp t
    always_comb
    begin
        tc          = (t_param > bez_pkg::T_ONE) ? bez_pkg::T_ONE : t_param;
        split0_next = req_type;
        t0_next     = tc;
        d0_next     = bez_pkg::T_ONE - tc;
    end

    // Stage 1: squares and first-level lerp steps
    always_comb
    begin
        pdd         = d0_reg * d0_reg;
        ptt         = t0_reg * t0_reg;
        split1_next = split0_reg;
        t1_next     = t0_reg;
        d1_next     = d0_reg;
        dd1_next    = pdd[F+TW-1:F];
        tt1_next    = ptt[F+TW-1:F];
        for (int i = 0; i < 3; i++)
        begin
            m1_next[i].x = bez_pkg::lerp_mul(ctl.p[i].x, ctl.p[i+1].x, t0_reg);
            m1_next[i].y = bez_pkg::lerp_mul(ctl.p[i].y, ctl.p[i+1].y, t0_reg);
        end
    end

    // Stage 2: Bernstein weights and a, b, c
    always_comb
    begin
        pw0         = d1_reg * dd1_reg;
        pw3         = t1_reg * tt1_reg;
        pw1         = dd1_reg * t1_reg;
        pw2         = d1_reg * tt1_reg;
        pw1x3       = {2'b00, pw1} + {1'b0, pw1, 1'b0};
        pw2x3       = {2'b00, pw2} + {1'b0, pw2, 1'b0};
        split2_next = split1_reg;
        t2_next     = t1_reg;
        w2_next[0]  = {{(WW-TW){1'b0}}, pw0[F+TW-1:F]};
        w2_next[1]  = pw1x3[F+WW-1:F];
        w2_next[2]  = pw2x3[F+WW-1:F];
        w2_next[3]  = {{(WW-TW){1'b0}}, pw3[F+TW-1:F]};
        for (int i = 0; i < 3; i++)
        begin
            l2_next[i].x = bez_pkg::lerp_add(ctl.p[i].x, m1_reg[i].x);
            l2_next[i].y = bez_pkg::lerp_add(ctl.p[i].y, m1_reg[i].y);
        end
    end

    // Stage 3: weighted control points and second-level steps
    always_comb
    begin
        split3_next = split2_reg;
        t3_next     = t2_reg;
        for (int i = 0; i < 4; i++)
        begin
            e3_next[i].x = bez_pkg::wmul(ctl.p[i].x, w2_reg[i]);
            e3_next[i].y = bez_pkg::wmul(ctl.p[i].y, w2_reg[i]);
        end
        for (int i = 0; i < 3; i++)
            l3_next[i] = l2_reg[i];
        for (int i = 0; i < 2; i++)
        begin
            m3_next[i].x = bez_pkg::lerp_mul(l2_reg[i].x, l2_reg[i+1].x, t2_reg);
            m3_next[i].y = bez_pkg::lerp_mul(l2_reg[i].y, l2_reg[i+1].y, t2_reg);
        end
    end

    // Stage 4: sum the weighted points, form ab and bc
    always_comb
    begin
        split4_next = split3_reg;
        t4_next     = t3_reg;
        ev4_next.x  = bez_pkg::sat(bez_pkg::ext_w(e3_reg[0].x) + bez_pkg::ext_w(e3_reg[1].x)
                                 + bez_pkg::ext_w(e3_reg[2].x) + bez_pkg::ext_w(e3_reg[3].x));
        ev4_next.y  = bez_pkg::sat(bez_pkg::ext_w(e3_reg[0].y) + bez_pkg::ext_w(e3_reg[1].y)
                                 + bez_pkg::ext_w(e3_reg[2].y) + bez_pkg::ext_w(e3_reg[3].y));
        a4_next     = l3_reg[0];
        c4_next     = l3_reg[2];
        ab4_next.x  = bez_pkg::lerp_add(l3_reg[0].x, m3_reg[0].x);
        ab4_next.y  = bez_pkg::lerp_add(l3_reg[0].y, m3_reg[0].y);
        bc4_next.x  = bez_pkg::lerp_add(l3_reg[1].x, m3_reg[1].x);
        bc4_next.y  = bez_pkg::lerp_add(l3_reg[1].y, m3_reg[1].y);
    end

    // Stage 5: step from ab toward bc
    always_comb
    begin
        split5_next = split4_reg;
        ev5_next    = ev4_reg;
        a5_next     = a4_reg;
        c5_next     = c4_reg;
        ab5_next    = ab4_reg;
        bc5_next    = bc4_reg;
        m5_next.x   = bez_pkg::lerp_mul(ab4_reg.x, bc4_reg.x, t4_reg);
        m5_next.y   = bez_pkg::lerp_mul(ab4_reg.y, bc4_reg.y, t4_reg);
    end

    // Stage 6: abc
    always_comb
    begin
        split6_next = split5_reg;
        ev6_next    = ev5_reg;
        a6_next     = a5_reg;
        c6_next     = c5_reg;
        ab6_next    = ab5_reg;
        bc6_next    = bc5_reg;
        abc6_next.x = bez_pkg::lerp_add(ab5_reg.x, m5_reg.x);
        abc6_next.y = bez_pkg::lerp_add(ab5_reg.y, m5_reg.y);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // Payload registers, each loaded when its stage advances
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            split0_reg <= split0_next;
            t0_reg     <= t0_next;
            d0_reg     <= d0_next;
        end
        if (rdy[1])
        begin
            split1_reg <= split1_next;
            t1_reg     <= t1_next;
            d1_reg     <= d1_next;
            dd1_reg    <= dd1_next;
            tt1_reg    <= tt1_next;
            m1_reg     <= m1_next;
        end
        if (rdy[2])
        begin
            split2_reg <= split2_next;
            t2_reg     <= t2_next;
            w2_reg     <= w2_next;
            l2_reg     <= l2_next;
        end
        if (rdy[3])
        begin
            split3_reg <= split3_next;
            t3_reg     <= t3_next;
            e3_reg     <= e3_next;
            l3_reg     <= l3_next;
            m3_reg     <= m3_next;
        end
        if (rdy[4])
        begin
            split4_reg <= split4_next;
            t4_reg     <= t4_next;
            ev4_reg    <= ev4_next;
            a4_reg     <= a4_next;
            c4_reg     <= c4_next;
            ab4_reg    <= ab4_next;
            bc4_reg    <= bc4_next;
        end
        if (rdy[5])
        begin
            split5_reg <= split5_next;
            ev5_reg    <= ev5_next;
            a5_reg     <= a5_next;
            c5_reg     <= c5_next;
            ab5_reg    <= ab5_next;
            bc5_reg    <= bc5_next;
            m5_reg     <= m5_next;
        end
        if (rdy[6])
        begin
            split6_reg <= split6_next;
            ev6_reg    <= ev6_next;
            a6_reg     <= a6_next;
            c6_reg     <= c6_next;
            ab6_reg    <= ab6_next;
            bc6_reg    <= bc6_next;
            abc6_reg   <= abc6_next;
        end
    end

    // Lay the finished request out in output order
    always_comb
    begin
        res.split = split6_reg;
        res.pt[0] = split6_reg ? ctl.p[0] : ev6_reg;
        res.pt[1] = a6_reg;
        res.pt[2] = ab6_reg;
        res.pt[3] = abc6_reg;
        res.pt[4] = abc6_reg;
        res.pt[5] = bc6_reg;
        res.pt[6] = c6_reg;
        res.pt[7] = ctl.p[3];
    end

    assign res_valid = v_reg[6];

endmodule

// File: hw/rtl/bez_serializer.sv
// Output register that streams the points of a finished request, one point per cycle while out_stall is low.
module bez_serializer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        res_valid,
    output logic                        res_ready,
    input  bez_pkg::res_t               res,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [bez_pkg::CW-1:0] out_x,
    output logic signed [bez_pkg::CW-1:0] out_y,
    output logic [2:0]                  point_index,
    output logic                        last_point
);

    logic           valid_reg, valid_next;
    logic [2:0]     cnt_reg, cnt_next;
    bez_pkg::res_t  pts_reg;
    logic           fire;
    logic           last;
    logic           load;

    assign last      = !pts_reg.split || (cnt_reg == 3'(bez_pkg::NPTS - 1));
    assign fire      = valid_reg && !out_stall;
    assign res_ready = !valid_reg || (fire && last);
    assign load      = res_valid && res_ready;

    // Advance through the points, reload after the last one
    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (fire)
        begin
            if (last)
                valid_next = 1'b0;
            else
                cnt_next = cnt_reg + 3'd1;
        end
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold the request's points
    always_ff @(posedge clk)
    begin
        if (load)
            pts_reg <= res;
    end

    assign out_valid   = valid_reg;
    assign out_x       = pts_reg.pt[cnt_reg].x;
    assign out_y       = pts_reg.pt[cnt_reg].y;
    assign point_index = cnt_reg;
    assign last_point  = last;

endmodule

// File: hw/rtl/cubic_bezier_eval_and_split.sv
// Throughput: one request enters per cycle while in_stall is low; the seven-stage
// pipeline holds up to seven requests while the output register streams one point
// per cycle while out_stall is low: an evaluate yields one point and a split eight.
// Reset: rst_n clears all valid bits and the control points to zero.
module cubic_bezier_eval_and_split (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bez_pkg::ADDR_W-1:0]        paddr,
    input  logic [bez_pkg::DATA_W-1:0]        pwdata,
    output logic [bez_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [bez_pkg::TW-1:0]            t_param,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bez_pkg::CW-1:0]     out_x,
    output logic signed [bez_pkg::CW-1:0]     out_y,
    output logic [2:0]                        point_index,
    output logic                              last_point
);

    bez_pkg::ctl_t  ctl;
    bez_pkg::res_t  res;
    logic           res_valid;
    logic           res_ready;

    // Control point registers
    bez_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ctl     (ctl)
    );

    // Arithmetic pipeline
    bez_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .t_param   (t_param),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Point stream
    bez_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .point_index (point_index),
        .last_point  (last_point)
    );

endmodule
